@@ design/gbs_pkg.sv @@
// Shared types and constants for the geometric bucket sparsifier.
// Used by gbs_front, gbs_fifo, gbs_back and the top level; no dependencies.
`default_nettype none

package gbs_pkg;

  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned COUNT_BITS    = 63;
  localparam int unsigned FACTOR_BITS   = 32;

  // Growth factor after reset: 1.0 in Q16.16.
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 32'd65536;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Depth of the queue between front and back; a power of two.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_ADDR_BITS = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [POSITION_BITS-1:0] entry_position;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     entry_last;
  } entry_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] bucket_start;
    logic [COUNT_BITS-1:0]    bucket_total;
    logic                     bucket_last;
  } bucket_t;

  // One classified entry as it travels from the front to the back.
  typedef struct packed {
    logic [POSITION_BITS-1:0] position;
    logic [COUNT_BITS-1:0]    count;
    logic                     last;
    logic                     opens;
  } work_t;

endpackage

`default_nettype wire

@@ design/gbs_front.sv @@
// Front part: accepts entries, keeps the running sum and the bucket threshold,
// and marks each entry that opens a bucket. Depends on gbs_pkg.
`default_nettype none

module gbs_front #(
  parameter int unsigned FACTOR_FRACTION_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire gbs_pkg::entry_t                      in_data_i,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [gbs_pkg::FACTOR_BITS-1:0]      cfg_data_i,
  output logic                                      push_valid_o,
  input  wire logic                                 push_ready_i,
  output gbs_pkg::work_t                            push_data_o
);

  localparam int unsigned CW = gbs_pkg::COUNT_BITS;
  localparam logic [32:0] FactorOne = 33'd1 << FACTOR_FRACTION_BITS;

  logic [gbs_pkg::FACTOR_BITS-1:0] factor_q;
  logic [CW-1:0] sum_q, sum_d;
  logic [CW-1:0] thr_q, thr_d;
  logic          stale_q, stale_d;
  logic [63:0]   prod_lo_q, prod_hi_q;

  logic          factor_le_one;
  logic          accept;
  logic [CW:0]   sum_ext, inc_ext;
  logic [CW-1:0] sum_new, inc;
  logic          opens;
  logic [95:0]   prod_full, prod_shift;
  logic [CW-1:0] scaled, thr_grow;

  assign factor_le_one = {1'b0, factor_q} <= FactorOne;
  // The scaled threshold comes from registered products, so it is stale in the
  // cycle after the threshold or the factor changes.
  assign in_ready_o = push_ready_i && (!stale_q || factor_le_one);
  assign accept     = in_valid_i && in_ready_o;

  assign sum_ext = {1'b0, sum_q} + {1'b0, in_data_i.entry_count};
  assign sum_new = sum_ext[CW] ? gbs_pkg::COUNT_MAX : sum_ext[CW-1:0];
  assign opens   = sum_new >= thr_q;

  assign inc_ext = {1'b0, thr_q} + (CW+1)'(1);
  assign inc     = inc_ext[CW] ? gbs_pkg::COUNT_MAX : inc_ext[CW-1:0];

  assign prod_full  = 96'(prod_lo_q) + {prod_hi_q, 32'd0};
  assign prod_shift = prod_full >> FACTOR_FRACTION_BITS;
  assign scaled     = (|prod_shift[95:CW]) ? gbs_pkg::COUNT_MAX : prod_shift[CW-1:0];
  assign thr_grow   = (factor_le_one || inc >= scaled) ? inc : scaled;

  always_comb begin
    sum_d   = sum_q;
    thr_d   = thr_q;
    stale_d = cfg_valid_i;
    if (accept) begin
      if (in_data_i.entry_last) begin
        sum_d   = '0;
        thr_d   = CW'(1);
        stale_d = 1'b1;
      end else begin
        sum_d = sum_new;
        if (opens) begin
          thr_d   = thr_grow;
          stale_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= gbs_pkg::FACTOR_RESET;
      sum_q    <= '0;
      thr_q    <= CW'(1);
      stale_q  <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        factor_q <= cfg_data_i;
      end
      sum_q   <= sum_d;
      thr_q   <= thr_d;
      stale_q <= stale_d;
    end
  end

  // Two 32x32 partial products of factor times threshold, refreshed every cycle.
  always_ff @(posedge clk_i) begin
    prod_lo_q <= 64'(factor_q) * 64'(thr_q[31:0]);
    prod_hi_q <= 64'(factor_q) * 64'(32'(thr_q >> 32));
  end

  assign push_valid_o         = accept;
  assign push_data_o.position = in_data_i.entry_position;
  assign push_data_o.count    = in_data_i.entry_count;
  assign push_data_o.last     = in_data_i.entry_last;
  assign push_data_o.opens    = opens;

endmodule

`default_nettype wire

@@ design/gbs_fifo.sv @@
// Short queue of classified entries between the front and the back part.
// Depends on gbs_pkg.
`default_nettype none

module gbs_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire gbs_pkg::work_t  push_data_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output gbs_pkg::work_t       pop_data_o
);

  localparam int unsigned AW = gbs_pkg::QUEUE_ADDR_BITS;

  gbs_pkg::work_t slots_q [gbs_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [AW:0]    count_q;
  logic           push, pop;

  assign push_ready_o = count_q != (AW+1)'(gbs_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/gbs_back.sv @@
// Back part: accumulates the open bucket and emits finished buckets through an
// output register and a second holding register. Depends on gbs_pkg.
`default_nettype none

module gbs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  input  wire gbs_pkg::work_t  pop_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output gbs_pkg::bucket_t     out_data_o
);

  localparam int unsigned CW = gbs_pkg::COUNT_BITS;

  logic [gbs_pkg::POSITION_BITS-1:0] open_pos_q;
  logic [CW-1:0]                     open_tot_q;
  logic                              started_q;
  gbs_pkg::bucket_t                  out_q, hold_q;
  logic                              out_v_q, hold_v_q;

  logic                              out_fire, out_free, take;
  logic                              moves, emit_closed;
  logic [CW-1:0]                     base;
  logic [CW:0]                       tot_ext;
  logic [CW-1:0]                     tot_new;
  logic [gbs_pkg::POSITION_BITS-1:0] pos_new;
  gbs_pkg::bucket_t                  closed, final_b;

  assign out_fire    = out_v_q && out_ready_i;
  assign out_free    = !out_v_q || out_fire;
  assign pop_ready_o = !hold_v_q && out_free;
  assign take        = pop_valid_i && pop_ready_o;

  assign moves       = pop_data_i.opens && (pop_data_i.position != open_pos_q);
  assign emit_closed = moves && started_q;
  assign base        = moves ? '0 : open_tot_q;
  assign tot_ext     = {1'b0, base} + {1'b0, pop_data_i.count};
  assign tot_new     = tot_ext[CW] ? gbs_pkg::COUNT_MAX : tot_ext[CW-1:0];
  assign pos_new     = pop_data_i.opens ? pop_data_i.position : open_pos_q;

  assign closed.bucket_start  = open_pos_q;
  assign closed.bucket_total  = open_tot_q;
  assign closed.bucket_last   = 1'b0;
  assign final_b.bucket_start = pos_new;
  assign final_b.bucket_total = tot_new;
  assign final_b.bucket_last  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_pos_q <= '0;
      open_tot_q <= '0;
      started_q  <= 1'b0;
      out_v_q    <= 1'b0;
      hold_v_q   <= 1'b0;
    end else begin
      if (take) begin
        if (pop_data_i.last) begin
          open_pos_q <= '0;
          open_tot_q <= '0;
          started_q  <= 1'b0;
        end else begin
          open_pos_q <= pos_new;
          open_tot_q <= tot_new;
          started_q  <= 1'b1;
        end
      end
      priority if (hold_v_q && out_free) begin
        out_v_q  <= 1'b1;
        hold_v_q <= 1'b0;
      end else if (take && (emit_closed || pop_data_i.last)) begin
        out_v_q  <= 1'b1;
        hold_v_q <= emit_closed && pop_data_i.last;
      end else begin
        out_v_q <= out_v_q && !out_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (hold_v_q && out_free) begin
      out_q <= hold_q;
    end else if (take && emit_closed) begin
      out_q  <= closed;
      hold_q <= final_b;
    end else if (take && pop_data_i.last) begin
      out_q <= final_b;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ design/geometric_bucket_sparsifier.sv @@
// Top level of the geometric bucket sparsifier: front, queue and back part.
// Depends on gbs_pkg, gbs_front, gbs_fifo and gbs_back.
//
// Usage: entries (position, count, last) of a sparse function arrive on the
// in_* channel in ascending position order, one beat per entry. Finished
// buckets (opening position, saturated total, last flag) leave on the out_*
// channel. The cfg_* channel writes the Q16.16 growth factor; it is always
// ready and is meant to be written only while the block is idle.
// Throughput is one entry per cycle but for the stalls below. When the growth
// factor exceeds 1.0, in_ready_o drops in the cycle after an entry that opens
// a bucket or ends the stream, as the scaled threshold comes from a registered
// pair of 32x32 partial products. An entry that closes a bucket and ends the
// stream yields two beats and holds the back part until the held beat moves
// to the output register. Results go through the queue and output register.
// Reset clears the sums, sets the threshold to 1 and the factor to 1.0.
// When the receiver stalls, the output register and a holding register keep
// results, the queue fills, and only then does in_ready_o drop.
`default_nettype none

module geometric_bucket_sparsifier #(
  parameter int unsigned FACTOR_FRACTION_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire gbs_pkg::entry_t                 in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output gbs_pkg::bucket_t                     out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gbs_pkg::FACTOR_BITS-1:0] cfg_data_i
);

  // Handshake between the front part and the queue.
  logic           push_valid, push_ready;
  gbs_pkg::work_t push_data;
  // Handshake between the queue and the back part.
  logic           pop_valid, pop_ready;
  gbs_pkg::work_t pop_data;

  // The factor register takes every write beat at once.
  assign cfg_ready_o = 1'b1;

  gbs_front #(
    .FACTOR_FRACTION_BITS(FACTOR_FRACTION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Entries wait here, already classified, so the front keeps taking beats
  // while the back part waits for the receiver.
  gbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  gbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // Every accepted input beat lands in the queue in the same cycle.
  a_accept_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> push_valid)
    else $error("accepted entry was not pushed into the queue");

  // The front never pushes into a full queue.
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("entry pushed into a full queue");

  // A queue entry is popped only when the back part can place its results.
  a_pop_with_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |-> (!out_valid_o || out_ready_i))
    else $error("entry popped while the output register was busy");
`endif

endmodule

`default_nettype wire
